[src/mtp_pkg.sv]
// Shared widths, constants and request codes for the MT19937 generator.
package mtp_pkg;

  localparam int WORD_W            = 32;
  localparam int DEF_STATE_WORDS   = 624;
  localparam int DEF_MIDDLE_OFFSET = 397;

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hEFC6_0000;

  // request codes carried in the operation field
  localparam logic OP_NEXT = 1'b0;
  localparam logic OP_SEED = 1'b1;

endpackage

[src/mtp_if.sv]
// Valid/ready channel interfaces for generator requests and results.
interface mtp_in_if import mtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface mtp_out_if import mtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

[src/mtp_state_mem.sv]
// State word memory: one write port, two registered read ports.
module mtp_state_mem import mtp_pkg::*; #(
  parameter int DEPTH = DEF_STATE_WORDS,
  parameter int IDX_W = $clog2(DEF_STATE_WORDS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr_a,
  input  logic [IDX_W-1:0]  rd_addr_b,
  output logic [WORD_W-1:0] rd_data_a,
  output logic [WORD_W-1:0] rd_data_b
);

  logic [WORD_W-1:0] words_r [DEPTH];
  logic [WORD_W-1:0] rd_a_r;
  logic [WORD_W-1:0] rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= words_r[rd_addr_a];
      rd_b_r <= words_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

[src/mtp_twist.sv]
// Twist of one state word and tempering of the twisted word.
module mtp_twist import mtp_pkg::*; (
  input  logic [WORD_W-1:0] cur_word,
  input  logic [WORD_W-1:0] nxt_word,
  input  logic [WORD_W-1:0] far_word,
  output logic [WORD_W-1:0] new_word,
  output logic [WORD_W-1:0] tempered_word
);

  logic [WORD_W-1:0] combo;
  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] y1;
  logic [WORD_W-1:0] y2;
  logic [WORD_W-1:0] y3;

  // merge upper bit of the current word with lower bits of the next one
  assign combo    = (cur_word & UPPER_MASK) | (nxt_word & LOWER_MASK);
  assign mag      = nxt_word[0] ? TWIST_MATRIX : '0;
  assign new_word = far_word ^ (combo >> 1) ^ mag;

  // temper the fresh word
  assign y1            = new_word ^ (new_word >> 11);
  assign y2            = y1 ^ ((y1 << 7) & TEMPER_MASK_B);
  assign y3            = y2 ^ ((y2 << 15) & TEMPER_MASK_C);
  assign tempered_word = y3 ^ (y3 >> 18);

endmodule

[src/mersenne_twister_prng.sv]
// MT19937 generator: request channel in, tempered 32-bit words out.
//
// in_req carries requests: operation next returns one word on out_rsp,
// operation seed refills the state from seed_value and returns nothing.
// The state words live in one memory with two read ports. Twisting is done
// one word per next request: the word at the current position is rebuilt
// from itself (held in a register), its successor and the word at the
// middle offset, written back and tempered into the output register.
// A taken next request moves to the twist state, which writes its tempered
// word to the output register once that register is free. A new next
// request is taken only once the last one is written back (issue reads,
// then twist and write back; the next reads wait for that write).
// Seeding walks the memory one word at a time through the seed multiplier,
// during which in_req.ready is low. Reset runs the same fill with seed 5489.
// A stalled out_rsp holds its word; one further request may be taken and
// then waits in the twist stage until the output register frees up.
module mersenne_twister_prng import mtp_pkg::*; #(
  parameter int STATE_WORDS   = DEF_STATE_WORDS,
  parameter int MIDDLE_OFFSET = DEF_MIDDLE_OFFSET
) (
  input logic       clk,
  input logic       rst_n,
  mtp_in_if.sink    in_req,
  mtp_out_if.source out_rsp
);

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] OFF_IDX  = IDX_W'(MIDDLE_OFFSET);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TWIST = 5'b00010,
    ST_FILL0 = 5'b00100,
    ST_SMUL  = 5'b01000,
    ST_SADD  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  nxt_r, nxt_nxt;
  logic [IDX_W-1:0]  far_r, far_nxt;
  logic [IDX_W-1:0]  fill_idx_r, fill_idx_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] seed_word_r, seed_word_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              in_acc;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_nxt_word;
  logic [WORD_W-1:0] rd_far_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] tempered_word;
  logic [WORD_W-1:0] seed_sum;
  logic              out_free;

  assign in_req.ready    = (state_r == ST_IDLE);
  assign in_acc          = in_req.valid && in_req.ready;
  assign rd_en           = in_acc && (in_req.operation == OP_NEXT);
  assign out_free        = !out_valid_r || out_rsp.ready;
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.random_word = out_word_r;
  assign seed_sum        = prod_r + WORD_W'(fill_idx_r);

  mtp_state_mem #(
    .DEPTH (STATE_WORDS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (nxt_r),
    .rd_addr_b (far_r),
    .rd_data_a (rd_nxt_word),
    .rd_data_b (rd_far_word)
  );

  mtp_twist u_twist (
    .cur_word      (cur_r),
    .nxt_word      (rd_nxt_word),
    .far_word      (rd_far_word),
    .new_word      (new_word),
    .tempered_word (tempered_word)
  );

  // sequencer for twist requests and the seed fill
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    nxt_nxt       = nxt_r;
    far_nxt       = far_r;
    fill_idx_nxt  = fill_idx_r;
    cur_nxt       = cur_r;
    seed_word_nxt = seed_word_r;
    prod_nxt      = prod_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = new_word;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.operation == OP_SEED) begin
            seed_word_nxt = in_req.seed_value;
            state_nxt     = ST_FILL0;
          end else begin
            state_nxt = ST_TWIST;
          end
        end
      end
      ST_TWIST: begin
        // once the output register is free, write back the twisted word and advance all three pointers
        if (out_free) begin
          wr_en         = 1'b1;
          out_word_nxt  = tempered_word;
          out_valid_nxt = 1'b1;
          cur_nxt       = rd_nxt_word;
          pos_nxt       = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
          nxt_nxt       = (nxt_r == LAST_IDX) ? '0 : nxt_r + 1'b1;
          far_nxt       = (far_r == LAST_IDX) ? '0 : far_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FILL0: begin
        // word zero is the seed itself; restart the twist round
        wr_en        = 1'b1;
        wr_addr      = '0;
        wr_data      = seed_word_r;
        cur_nxt      = seed_word_r;
        pos_nxt      = '0;
        nxt_nxt      = IDX_W'(1);
        far_nxt      = OFF_IDX;
        fill_idx_nxt = IDX_W'(1);
        state_nxt    = ST_SMUL;
      end
      ST_SMUL: begin
        prod_nxt  = SEED_MULT * (seed_word_r ^ (seed_word_r >> 30));
        state_nxt = ST_SADD;
      end
      ST_SADD: begin
        wr_en         = 1'b1;
        wr_addr       = fill_idx_r;
        wr_data       = seed_sum;
        seed_word_nxt = seed_sum;
        fill_idx_nxt  = fill_idx_r + 1'b1;
        state_nxt     = (fill_idx_r == LAST_IDX) ? ST_IDLE : ST_SMUL;
      end
      default: begin
        state_nxt = ST_FILL0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL0;
      seed_word_r <= DEFAULT_SEED;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      nxt_r       <= IDX_W'(1);
      far_r       <= OFF_IDX;
      fill_idx_r  <= IDX_W'(1);
    end else begin
      state_r     <= state_nxt;
      seed_word_r <= seed_word_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      nxt_r       <= nxt_nxt;
      far_r       <= far_nxt;
      fill_idx_r  <= fill_idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  // expected middle pointer for the current position
  logic [IDX_W:0] far_sum;
  logic [IDX_W:0] far_chk;
  assign far_sum = {1'b0, pos_r} + {1'b0, OFF_IDX};
  assign far_chk = (far_sum >= (IDX_W+1)'(STATE_WORDS))
                 ? far_sum - (IDX_W+1)'(STATE_WORDS) : far_sum;

  a_nxt_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_r == ((pos_r == LAST_IDX) ? '0 : IDX_W'(pos_r + 1'b1)))
    else $error("successor pointer out of step with position");

  a_far_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, far_r} == far_chk)
    else $error("middle pointer out of step with position");

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.operation == OP_SEED) |=> (state_r == ST_FILL0 && !wr_en ||
      state_r == ST_FILL0))
    else $error("seed request did not start the fill");

  a_twist_waits_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TWIST && out_valid_r && !out_rsp.ready) |=>
      (state_r == ST_TWIST && $stable(out_word_r)))
    else $error("twist overran a stalled result");

endmodule

[sim/mersenne_twister_prng_tb.sv]
// Self-checking testbench for the MT19937 generator: random requests, checked words.
module mersenne_twister_prng_tb import mtp_pkg::*; ();

  localparam int STATE_WORDS   = DEF_STATE_WORDS;
  localparam int MIDDLE_OFFSET = DEF_MIDDLE_OFFSET;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;

  // Track the generator state and the words it owes the result channel.
  class mt_scoreboard;
    logic [WORD_W-1:0] state_words [STATE_WORDS];
    int unsigned       word_pos;
    logic [WORD_W-1:0] owed_words [$];
    int unsigned       errors;

    function new();
      errors = 0;
      load_seed(DEFAULT_SEED);
    endfunction

    // Refill the state and force a twist on the next word.
    function void load_seed(logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] prev;
      state_words[0] = seed;
      for (int i = 1; i < STATE_WORDS; i++) begin
        prev = state_words[i-1];
        state_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
      end
      word_pos = STATE_WORDS;
    endfunction

    // Note an accepted request; a next request owes one tempered word.
    function void note_request(logic op, logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] mixed;
      logic [WORD_W-1:0] y;
      int                succ;
      int                mid;
      if (op == OP_SEED) begin
        load_seed(seed);
        return;
      end
      if (word_pos >= STATE_WORDS) begin
        for (int i = 0; i < STATE_WORDS; i++) begin
          succ  = (i + 1) % STATE_WORDS;
          mid   = (i + MIDDLE_OFFSET) % STATE_WORDS;
          mixed = (state_words[i] & UPPER_MASK) | (state_words[succ] & LOWER_MASK);
          state_words[i] = state_words[mid] ^ (mixed >> 1) ^
                           (mixed[0] ? TWIST_MATRIX : '0);
        end
        word_pos = 0;
      end
      // temper on the way out, leave the stored word untouched
      y = state_words[word_pos];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_MASK_B);
      y = y ^ ((y << 15) & TEMPER_MASK_C);
      y = y ^ (y >> 18);
      owed_words.push_back(y);
      word_pos++;
    endfunction

    // Compare a delivered word with the oldest one owed.
    function void check_word(logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] want;
      if (owed_words.size() == 0) begin
        $display("%0t: random_word expected none actual %h", $time, word);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (word !== want) begin
        $display("%0t: random_word expected %h actual %h", $time, want, word);
        errors++;
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic req_gaps;
  logic rsp_stalls;
  logic long_hold_req;

  mtp_in_if  in_req ();
  mtp_out_if out_rsp ();

  mt_scoreboard sb = new();

  mersenne_twister_prng #(
    .STATE_WORDS   (STATE_WORDS),
    .MIDDLE_OFFSET (MIDDLE_OFFSET)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // Generate the clock, period 2.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive one request; call just after a falling edge, return after the next one.
  task automatic send_req(input logic op, input logic [WORD_W-1:0] seed);
    if (req_gaps && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.operation  <= op;
    in_req.seed_value <= seed;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(op, seed);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic drain_words();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_next();
    send_req(OP_NEXT, $urandom());
  endtask

  // Stall the result channel in random bursts, or for one long hold on request.
  initial begin
    int hold;
    hold          = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end else if (hold == 0 && rsp_stalls && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 13);
      end
      if (hold > 0) begin
        out_rsp.ready <= 1'b0;
        hold--;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // Check every delivered word.
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      sb.check_word(out_rsp.random_word);
    end
  end

  // Abort a hung run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [WORD_W-1:0] seed;
    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.operation  = OP_NEXT;
    in_req.seed_value = '0;
    req_gaps          = 1'b1;
    rsp_stalls        = 1'b1;
    long_hold_req     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first word after reset, seed extremes, back-to-back seeds
    send_req(OP_NEXT, '0);
    send_req(OP_NEXT, '1);
    send_next();
    send_next();
    send_req(OP_SEED, '0);
    send_req(OP_NEXT, '1);
    send_next();
    send_req(OP_SEED, '1);
    send_req(OP_NEXT, '0);
    send_next();
    send_req(OP_SEED, DEFAULT_SEED);
    send_next();
    send_req(OP_SEED, 32'h8000_0000);
    send_req(OP_SEED, 32'h0000_0001);
    send_next();
    send_next();
    send_req(OP_SEED, 32'h5555_5555);
    send_req(OP_SEED, 32'hAAAA_AAAA);
    send_next();
    send_next();

    // pause the sender until the results are all in
    drain_words();

    // hold off the receiver while requests keep coming, filling the pipe
    long_hold_req = 1'b1;
    req_gaps      = 1'b0;
    repeat (12) send_next();
    req_gaps = 1'b1;

    // long run of next requests, well past one full twist
    repeat (640) send_next();

    // mixed requests with occasional reseeds
    repeat (150) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0:       seed = '0;
          1:       seed = '1;
          default: seed = $urandom();
        endcase
        send_req(OP_SEED, seed);
      end else begin
        send_next();
      end
    end

    // closing stretch with no idling on either side
    req_gaps   = 1'b0;
    rsp_stalls = 1'b0;
    repeat (40) send_next();

    drain_words();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
